// ===== rtl/wfe_pkg.sv =====
// Shared types and constants of the single-LED frame encoder.
package wfe_pkg;

  // Longest strip the encoder addresses
  localparam int MAX_LEDS = 32;

  // Field widths
  localparam int POS_W    = 6;
  localparam int COLOR_W  = 24;
  localparam int HIGH_W   = 12;
  localparam int RESET_W  = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int BIT_W    = 5;

  // Last bit index of one 24-bit LED word
  localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(COLOR_W - 1);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZERO_HIGH  = 2'd0,
    CFG_ONE_HIGH   = 2'd1,
    CFG_BIT_PERIOD = 2'd2,
    CFG_RESET_LEN  = 2'd3
  } cfg_idx_t;

  // Waveform phases
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_RESET_A = 3'd1,
    PH_PAD     = 3'd2,
    PH_COLOR   = 3'd3,
    PH_RESET_B = 3'd4
  } phase_t;

  // Classified tick as it waits in the queue
  typedef struct packed {
    logic               start;
    logic               pos_ok;
    logic [POS_W-1:0]   pad;
    logic [COLOR_W-1:0] color;
  } item_t;

endpackage

// ===== rtl/wfe_front.sv =====
// Front end: accept ticks, check the LED position and pack the color word.
module wfe_front (
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_start_request,
  input  logic [wfe_pkg::POS_W-1:0] in_led_position,
  input  logic [7:0]                in_red,
  input  logic [7:0]                in_green,
  input  logic [7:0]                in_blue,
  input  logic                      q_full,
  output logic                      q_push,
  output wfe_pkg::item_t            q_item
);
  import wfe_pkg::*;

  // Hold the input while the queue has no room
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Classify the request and prepare the frame data
  always_comb begin
    q_item.start  = in_start_request;
    q_item.pos_ok = (in_led_position != '0) &&
                    ({1'b0, in_led_position} <= (POS_W + 1)'(MAX_LEDS));
    q_item.pad    = in_led_position - POS_W'(1);
    q_item.color  = {in_green, in_red, in_blue};
  end

endmodule

// ===== rtl/wfe_queue.sv =====
// Two-entry queue between the front end and the waveform engine.
module wfe_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  wfe_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output wfe_pkg::item_t pop_item
);
  import wfe_pkg::*;

  item_t      mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_item  = mem_r[rd_ptr_r];

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== rtl/wfe_back.sv =====
// Waveform engine: frame state machine, timing registers and result register.
module wfe_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [wfe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wfe_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          q_not_empty,
  input  wfe_pkg::item_t                q_item,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_data_line,
  output logic                          out_busy_res,
  output logic                          out_frame_done,
  output logic                          out_request_rejected
);
  import wfe_pkg::*;

  // Timing registers
  logic [HIGH_W-1:0]  zero_high_r;
  logic [HIGH_W-1:0]  one_high_r;
  logic [HIGH_W-1:0]  period_r;
  logic [RESET_W-1:0] reset_len_r;

  // Frame state
  phase_t             phase_r, phase_nxt;
  logic [RESET_W-1:0] tick_r, tick_nxt;
  logic [BIT_W-1:0]   bit_r, bit_nxt;
  logic [POS_W-1:0]   pad_r, pad_nxt;
  logic [COLOR_W-1:0] color_r, color_nxt;

  // State after the request of this tick is applied
  phase_t             ph_c;
  logic [RESET_W-1:0] tick_c;
  logic [BIT_W-1:0]   bit_c;
  logic [POS_W-1:0]   pad_c;
  logic [COLOR_W-1:0] color_c;
  logic               active;
  logic               rej_c;

  logic [RESET_W-1:0] rst_len;
  logic [HIGH_W-1:0]  per_len;
  logic [RESET_W:0]   tick_inc;
  logic               reset_end;
  logic               bit_end;
  logic [POS_W-1:0]   pad_dec;

  // Results of this tick
  logic               line_c;
  logic               busy_c;
  logic               done_c;
  logic               bit_val;
  logic [HIGH_W-1:0]  high_len;

  logic               out_valid_r;
  logic               line_r, busy_r, done_r, rej_r;

  // Take the next tick whenever the result slot frees up
  assign q_pop     = q_not_empty && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data_line        = line_r;
  assign out_busy_res         = busy_r;
  assign out_frame_done       = done_r;
  assign out_request_rejected = rej_r;

  // Write timing registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_high_r <= HIGH_W'(30);
      one_high_r  <= HIGH_W'(80);
      period_r    <= HIGH_W'(125);
      reset_len_r <= RESET_W'(30000);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ZERO_HIGH:  zero_high_r <= cfg_wdata[HIGH_W-1:0];
        CFG_ONE_HIGH:   one_high_r  <= cfg_wdata[HIGH_W-1:0];
        CFG_BIT_PERIOD: period_r    <= cfg_wdata[HIGH_W-1:0];
        CFG_RESET_LEN:  reset_len_r <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  // Clamp zero lengths to one tick
  assign rst_len = (reset_len_r == '0) ? RESET_W'(1) : reset_len_r;
  assign per_len = (period_r == '0) ? HIGH_W'(1) : period_r;

  // Apply a new request or flag it
  always_comb begin
    active  = (phase_r == PH_RESET_A) || (phase_r == PH_PAD) ||
              (phase_r == PH_COLOR) || (phase_r == PH_RESET_B);
    ph_c    = active ? phase_r : PH_IDLE;
    tick_c  = tick_r;
    bit_c   = bit_r;
    pad_c   = pad_r;
    color_c = color_r;
    rej_c   = 1'b0;
    if (q_item.start) begin
      if (active || !q_item.pos_ok) begin
        rej_c = 1'b1;
      end else begin
        ph_c    = PH_RESET_A;
        tick_c  = '0;
        bit_c   = '0;
        pad_c   = q_item.pad;
        color_c = q_item.color;
      end
    end
  end

  assign tick_inc  = {1'b0, tick_c} + (RESET_W + 1)'(1);
  assign reset_end = (tick_inc >= {1'b0, rst_len});
  assign bit_end   = (tick_inc >= (RESET_W + 1)'(per_len));
  assign pad_dec   = pad_c - POS_W'(1);

  // Next state
  always_comb begin
    phase_nxt = ph_c;
    tick_nxt  = tick_c;
    bit_nxt   = bit_c;
    pad_nxt   = pad_c;
    color_nxt = color_c;
    unique case (ph_c)
      PH_RESET_A, PH_RESET_B: begin
        if (reset_end) begin
          tick_nxt = '0;
          if (ph_c == PH_RESET_A) begin
            bit_nxt   = '0;
            phase_nxt = (pad_c != '0) ? PH_PAD : PH_COLOR;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end else begin
          tick_nxt = tick_inc[RESET_W-1:0];
        end
      end
      PH_PAD, PH_COLOR: begin
        if (bit_end) begin
          tick_nxt = '0;
          if (bit_c >= LAST_BIT) begin
            bit_nxt = '0;
            if (ph_c == PH_PAD) begin
              pad_nxt = pad_dec;
              if (pad_dec == '0) phase_nxt = PH_COLOR;
            end else begin
              phase_nxt = PH_RESET_B;
            end
          end else begin
            bit_nxt = bit_c + BIT_W'(1);
          end
        end else begin
          tick_nxt = tick_inc[RESET_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // Outputs of this tick
  always_comb begin
    bit_val = 1'b0;
    if ((ph_c == PH_COLOR) && (bit_c <= LAST_BIT)) begin
      bit_val = color_c[LAST_BIT - bit_c];
    end
    high_len = bit_val ? one_high_r : zero_high_r;
    line_c   = 1'b0;
    busy_c   = 1'b0;
    done_c   = 1'b0;
    unique case (ph_c)
      PH_RESET_A: busy_c = 1'b1;
      PH_RESET_B: begin
        busy_c = 1'b1;
        done_c = reset_end;
      end
      PH_PAD, PH_COLOR: begin
        busy_c = 1'b1;
        line_c = (tick_c < RESET_W'(high_len));
      end
      default: ;
    endcase
  end

  // Advance frame state on each consumed tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r  <= '0;
      bit_r   <= '0;
      pad_r   <= '0;
      color_r <= '0;
    end else if (q_pop) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      bit_r   <= bit_nxt;
      pad_r   <= pad_nxt;
      color_r <= color_nxt;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      line_r <= line_c;
      busy_r <= busy_c;
      done_r <= done_c;
      rej_r  <= rej_c;
    end
  end

endmodule

// ===== rtl/ws2812_single_led_frame_encoder.sv =====
// Top level of the single-LED serial frame encoder.
// Each input item is one tick of the LED data waveform and yields exactly one
// result item: the data line level, busy, frame done and request rejected for
// that tick. An item is taken every cycle while results are drained every
// cycle. A result is registered: the item waits in the two-entry queue and is
// applied to the frame state as it moves into the result register. A stalled
// result holds the back end, so the input stalls once two more items fill the
// queue. A request on a tick starts a frame of reset low, 24 zero bits per LED
// before the addressed one, the green, red and blue bytes MSB first, and a
// closing reset. Requests while a frame runs or with a position outside 1 to
// 32 are flagged and dropped. Timing registers must be written on the cfg
// port only while no item waits in the queue or the result register; the
// block itself does not enforce this. A write applies from the next item
// taken.
module ws2812_single_led_frame_encoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [wfe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wfe_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_start_request,
  input  logic [wfe_pkg::POS_W-1:0]     in_led_position,
  input  logic [7:0]                    in_red,
  input  logic [7:0]                    in_green,
  input  logic [7:0]                    in_blue,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_data_line,
  output logic                          out_busy_res,
  output logic                          out_frame_done,
  output logic                          out_request_rejected
);
  import wfe_pkg::*;

  logic  q_full;
  logic  q_push;
  logic  q_pop;
  logic  q_not_empty;
  item_t push_item;
  item_t pop_item;

  // Accept and classify ticks
  wfe_front u_front (
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_start_request (in_start_request),
    .in_led_position  (in_led_position),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_item           (push_item)
  );

  // Decouple front and back
  wfe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (pop_item)
  );

  // Generate the waveform
  wfe_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .q_not_empty          (q_not_empty),
    .q_item               (pop_item),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_data_line        (out_data_line),
    .out_busy_res         (out_busy_res),
    .out_frame_done       (out_frame_done),
    .out_request_rejected (out_request_rejected)
  );

endmodule
